>>> rtl/opd_pkg.sv
// Shared types and constants for the optical presence debouncer.
`timescale 1ns / 1ps

package opd_pkg;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 32;
  localparam int unsigned ThreshBits  = 13;
  localparam int unsigned RailBits    = 12;
  localparam int unsigned DurBits     = 32;
  localparam int unsigned RepeatBits  = 8;

  localparam logic [RepeatBits-1:0] RepeatMax = 8'hff;

  typedef enum logic [1:0] {
    LVL_UNKNOWN = 2'd0,
    LVL_BLOCKED = 2'd1,
    LVL_OPEN    = 2'd2
  } opd_level_e;

  typedef enum logic [1:0] {
    FLT_NONE   = 2'd0,
    FLT_THRESH = 2'd1,
    FLT_ADC    = 2'd2,
    FLT_RAIL   = 2'd3
  } opd_fault_e;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_BLOCKED_THR = 3'd0,
    REG_OPEN_THR    = 3'd1,
    REG_DEBOUNCE    = 3'd2,
    REG_RAIL_MIN    = 3'd3,
    REG_RAIL_MAX    = 3'd4,
    REG_RAIL_DUR    = 3'd5
  } opd_reg_e;

  typedef struct packed {
    logic signed [ThreshBits-1:0] blocked_thr;
    logic signed [ThreshBits-1:0] open_thr;
    logic        [RepeatBits-1:0] debounce_cnt;
    logic        [RailBits-1:0]   rail_min;
    logic        [RailBits-1:0]   rail_max;
    logic        [DurBits-1:0]    rail_dur;
  } opd_cfg_t;

  localparam opd_cfg_t CfgReset = '{
    blocked_thr:  13'sd0,
    open_thr:     13'sd1,
    debounce_cnt: 8'd3,
    rail_min:     12'd0,
    rail_max:     12'd4095,
    rail_dur:     32'd1000
  };

endpackage

>>> rtl/optical_presence_debouncer.sv
// Top level of the optical presence debouncer: config registers and pipeline.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one ambient/lit ADC pair,
//   a sample_ok flag, a millisecond timestamp and a rail-check enable.
//   Output channel (out_valid_o/out_ready_i) returns one result per sample:
//   previous and new stable state, change flag, light delta and fault code.
//   Config channel (cfg_valid_i/cfg_ready_o) writes one register per
//   transfer by index; it is always ready. Write only while no sample is
//   in flight.
//   Path: a sample passes through the input register, then the result
//   register, before it is presented on the output.
//   Throughput: one sample per cycle; the input register drains into the
//   result register whenever the result register is empty or being taken.
//   A stalled receiver holds the result and, once the input register is
//   also full, deasserts in_ready_o.
//   Reset clears both pipeline stages, the debouncer and the fault timers
//   and loads the default register values; no warm-up is needed.
module optical_presence_debouncer #(
  parameter int unsigned ADC_BITS  = 12,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [opd_pkg::CfgIdxBits-1:0]        cfg_index_i,
  input  logic [opd_pkg::CfgDataBits-1:0]       cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [ADC_BITS-1:0]                   ambient_level_i,
  input  logic [ADC_BITS-1:0]                   lit_level_i,
  input  logic                                  sample_ok_i,
  input  logic [TIME_BITS-1:0]                  now_ms_i,
  input  logic                                  rail_check_enable_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [1:0]                            previous_state_o,
  output logic [1:0]                            stable_state_o,
  output logic                                  state_changed_o,
  output logic signed [opd_pkg::ThreshBits-1:0] light_delta_o,
  output logic [1:0]                            fault_code_o
);

  opd_pkg::opd_cfg_t cfg_q;
  logic              cfg_ok;

  logic                 in_valid_q;
  logic [ADC_BITS-1:0]  ambient_q, lit_q;
  logic                 ok_q, en_q;
  logic [TIME_BITS-1:0] now_q;

  logic                 out_valid_q;
  logic                 adv;

  opd_pkg::opd_level_e  prev_lvl, stab_lvl;
  logic                 changed;
  logic signed [opd_pkg::ThreshBits-1:0] delta;
  opd_pkg::opd_fault_e  fault;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= opd_pkg::CfgReset;
    end else if (cfg_valid_i) begin
      case (opd_pkg::opd_reg_e'(cfg_index_i))
        opd_pkg::REG_BLOCKED_THR: cfg_q.blocked_thr  <= cfg_data_i[opd_pkg::ThreshBits-1:0];
        opd_pkg::REG_OPEN_THR:    cfg_q.open_thr     <= cfg_data_i[opd_pkg::ThreshBits-1:0];
        opd_pkg::REG_DEBOUNCE:    cfg_q.debounce_cnt <= cfg_data_i[opd_pkg::RepeatBits-1:0];
        opd_pkg::REG_RAIL_MIN:    cfg_q.rail_min     <= cfg_data_i[opd_pkg::RailBits-1:0];
        opd_pkg::REG_RAIL_MAX:    cfg_q.rail_max     <= cfg_data_i[opd_pkg::RailBits-1:0];
        opd_pkg::REG_RAIL_DUR:    cfg_q.rail_dur     <= cfg_data_i[opd_pkg::DurBits-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ok = (cfg_q.blocked_thr < cfg_q.open_thr) && (cfg_q.debounce_cnt != '0);

  // advance the input register into the result register
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ambient_q <= ambient_level_i;
      lit_q     <= lit_level_i;
      ok_q      <= sample_ok_i;
      now_q     <= now_ms_i;
      en_q      <= rail_check_enable_i;
    end
  end

  opd_fault #(
    .ADC_BITS  (ADC_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_fault (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .cfg_i       (cfg_q),
    .cfg_ok_i    (cfg_ok),
    .sample_ok_i (ok_q),
    .ambient_i   (ambient_q),
    .lit_i       (lit_q),
    .now_i       (now_q),
    .rail_en_i   (en_q),
    .fault_o     (fault)
  );

  opd_debounce #(
    .ADC_BITS (ADC_BITS)
  ) u_debounce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .cfg_i       (cfg_q),
    .cfg_ok_i    (cfg_ok),
    .sample_ok_i (ok_q),
    .ambient_i   (ambient_q),
    .lit_i       (lit_q),
    .prev_o      (prev_lvl),
    .stable_o    (stab_lvl),
    .changed_o   (changed),
    .delta_o     (delta)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      previous_state_o <= prev_lvl;
      stable_state_o   <= stab_lvl;
      state_changed_o  <= changed;
      light_delta_o    <= delta;
      fault_code_o     <= fault;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/opd_fault.sv
// Fault tracker: threshold check, ADC failure and railed-reading timers.
`timescale 1ns / 1ps

module opd_fault #(
  parameter int unsigned ADC_BITS  = 12,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  opd_pkg::opd_cfg_t    cfg_i,
  input  logic                 cfg_ok_i,
  input  logic                 sample_ok_i,
  input  logic [ADC_BITS-1:0]  ambient_i,
  input  logic [ADC_BITS-1:0]  lit_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic                 rail_en_i,
  output opd_pkg::opd_fault_e  fault_o
);

  localparam int unsigned RW = (ADC_BITS > opd_pkg::RailBits) ? ADC_BITS : opd_pkg::RailBits;

  logic                rail_timing_q, rail_timing_d;
  logic                valid_timing_q, valid_timing_d;
  logic [TIME_BITS-1:0] rail_start_q, rail_start_d;
  logic [TIME_BITS-1:0] valid_start_q, valid_start_d;
  opd_pkg::opd_fault_e fault_q, fault_d;

  logic                 railed;
  logic [TIME_BITS-1:0] rail_diff, valid_diff;
  logic                 rail_elapsed, valid_elapsed;

  assign railed = (RW'(ambient_i) <= RW'(cfg_i.rail_min)) ||
                  (RW'(ambient_i) >= RW'(cfg_i.rail_max)) ||
                  (RW'(lit_i)     <= RW'(cfg_i.rail_min)) ||
                  (RW'(lit_i)     >= RW'(cfg_i.rail_max));

  // wrap-safe elapsed time
  assign rail_diff     = now_i - rail_start_q;
  assign valid_diff    = now_i - valid_start_q;
  assign rail_elapsed  = opd_pkg::DurBits'(rail_diff)  >= cfg_i.rail_dur;
  assign valid_elapsed = opd_pkg::DurBits'(valid_diff) >= cfg_i.rail_dur;

  always_comb begin
    rail_timing_d  = rail_timing_q;
    valid_timing_d = valid_timing_q;
    rail_start_d   = rail_start_q;
    valid_start_d  = valid_start_q;
    fault_d        = fault_q;
    if (!cfg_ok_i) begin
      fault_d = opd_pkg::FLT_THRESH;
    end else if (!sample_ok_i) begin
      fault_d        = opd_pkg::FLT_ADC;
      rail_timing_d  = 1'b0;
      valid_timing_d = 1'b0;
    end else if (railed && !rail_en_i) begin
      rail_timing_d  = 1'b0;
      valid_timing_d = 1'b0;
    end else if (railed) begin
      valid_timing_d = 1'b0;
      if (!rail_timing_q) begin
        rail_timing_d = 1'b1;
        rail_start_d  = now_i;
      end else if (rail_elapsed) begin
        fault_d = opd_pkg::FLT_RAIL;
      end
    end else begin
      rail_timing_d = 1'b0;
      if (fault_q != opd_pkg::FLT_NONE) begin
        if (!valid_timing_q) begin
          valid_timing_d = 1'b1;
          valid_start_d  = now_i;
        end else if (valid_elapsed) begin
          fault_d        = opd_pkg::FLT_NONE;
          valid_timing_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rail_timing_q  <= 1'b0;
      valid_timing_q <= 1'b0;
      fault_q        <= opd_pkg::FLT_NONE;
    end else if (adv_i) begin
      rail_timing_q  <= rail_timing_d;
      valid_timing_q <= valid_timing_d;
      fault_q        <= fault_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rail_start_q  <= rail_start_d;
      valid_start_q <= valid_start_d;
    end
  end

  assign fault_o = fault_d;

endmodule

>>> rtl/opd_debounce.sv
// Hysteresis classifier and repeat-count debouncer.
`timescale 1ns / 1ps

module opd_debounce #(
  parameter int unsigned ADC_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  opd_pkg::opd_cfg_t                 cfg_i,
  input  logic                              cfg_ok_i,
  input  logic                              sample_ok_i,
  input  logic [ADC_BITS-1:0]               ambient_i,
  input  logic [ADC_BITS-1:0]               lit_i,
  output opd_pkg::opd_level_e               prev_o,
  output opd_pkg::opd_level_e               stable_o,
  output logic                              changed_o,
  output logic signed [opd_pkg::ThreshBits-1:0] delta_o
);

  localparam int unsigned DW = (ADC_BITS + 1 > opd_pkg::ThreshBits) ?
                               ADC_BITS + 1 : opd_pkg::ThreshBits;

  opd_pkg::opd_level_e stable_q, stable_d;
  opd_pkg::opd_level_e cand_q, cand_d;
  logic [opd_pkg::RepeatBits-1:0] reps_q, reps_d, reps_n;

  logic signed [DW-1:0] delta;
  logic signed [DW-1:0] blk_thr, open_thr;
  opd_pkg::opd_level_e  seen;

  assign delta    = $signed(DW'(ambient_i)) - $signed(DW'(lit_i));
  assign blk_thr  = DW'(cfg_i.blocked_thr);
  assign open_thr = DW'(cfg_i.open_thr);
  assign delta_o  = sample_ok_i ? delta[opd_pkg::ThreshBits-1:0] : '0;

  always_comb begin
    if (delta <= blk_thr) begin
      seen = opd_pkg::LVL_BLOCKED;
    end else if (delta >= open_thr) begin
      seen = opd_pkg::LVL_OPEN;
    end else begin
      seen = stable_q;
    end
  end

  always_comb begin
    stable_d  = stable_q;
    cand_d    = cand_q;
    reps_d    = reps_q;
    reps_n    = reps_q;
    changed_o = 1'b0;
    if (sample_ok_i && cfg_ok_i) begin
      if (seen == opd_pkg::LVL_UNKNOWN || seen == stable_q) begin
        cand_d = opd_pkg::LVL_UNKNOWN;
        reps_d = '0;
      end else begin
        // saturating repeat count for the new candidate
        if (cand_q != seen) begin
          reps_n = opd_pkg::RepeatBits'(1);
        end else if (reps_q < opd_pkg::RepeatMax) begin
          reps_n = reps_q + opd_pkg::RepeatBits'(1);
        end
        cand_d = seen;
        reps_d = reps_n;
        if (reps_n >= cfg_i.debounce_cnt) begin
          changed_o = (stable_q != opd_pkg::LVL_UNKNOWN);
          stable_d  = seen;
          cand_d    = opd_pkg::LVL_UNKNOWN;
          reps_d    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= opd_pkg::LVL_UNKNOWN;
      cand_q   <= opd_pkg::LVL_UNKNOWN;
      reps_q   <= '0;
    end else if (adv_i) begin
      stable_q <= stable_d;
      cand_q   <= cand_d;
      reps_q   <= reps_d;
    end
  end

  assign prev_o   = stable_q;
  assign stable_o = stable_d;

endmodule
